// File: hw/rtl/ulfr_pkg.sv
// ----------------------------------------------------------------------------
// ulfr_pkg
// Shared constants, codes and helpers of the UART line framer.
// ----------------------------------------------------------------------------
package ulfr_pkg;

   localparam int DEFAULT_RX_DEPTH = 64;

   localparam int BYTE_W = 8;
   localparam int KIND_W = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int PEND_OUT_W = 6;

   localparam logic [KIND_W-1:0] KIND_BYTE    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_PROCESS = 3'd1;
   localparam logic [KIND_W-1:0] KIND_DONE    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_SILENCE = 3'd3;
   localparam logic [KIND_W-1:0] KIND_SECOND  = 3'd4;

   localparam logic [CSR_ADDR_W-1:0] CSR_END_FIRST     = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_END_SECOND    = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_SILENCE_TICKS = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_HOLD_SECONDS  = 3'd3;

   localparam logic [BYTE_W-1:0] RST_END_FIRST     = 8'd13;
   localparam logic [BYTE_W-1:0] RST_END_SECOND    = 8'd10;
   localparam logic [BYTE_W-1:0] RST_SILENCE_TICKS = 8'd2;
   localparam logic [BYTE_W-1:0] RST_HOLD_SECONDS  = 8'd5;

   localparam logic [BYTE_W-1:0] PRINT_LOW  = 8'h20;
   localparam logic [BYTE_W-1:0] START_MARK = 8'h01;
   localparam logic [BYTE_W-1:0] PRINT_HIGH = 8'h7F;

   function automatic logic is_junk(input logic [BYTE_W-1:0] b);
      return ((b < PRINT_LOW) && (b != START_MARK)) || (b > PRINT_HIGH);
   endfunction

endpackage

// File: hw/rtl/uart_line_framer_ring.sv
// ----------------------------------------------------------------------------
// uart_line_framer_ring
// Receive ring for UART bytes with a terminator-pair line framer and hold timer.
// ----------------------------------------------------------------------------
// Byte, done, silence and second words, and process words while held, give
// one result word. Else a process word skips leading junk byte by byte, scans
// the pending bytes for the terminator pair, then emits the line byte by byte
// (or one unframed word if none); all steps are set by the single read port
// of the ring RAM. One word is in work at a time. Synchronous reset clears
// pointers, counters and the held flag and restores register defaults; the RAM is not cleared.
module uart_line_framer_ring
   import ulfr_pkg::*;
#(
   parameter int RX_DEPTH = DEFAULT_RX_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,  // rx_byte[7:0]
   input  logic [2:0]            req_tuser,  // kind[2:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata,  // cmd_byte[7:0], command_held[8],
                                             // pending_count[14:9], dropped[15]
   output logic [1:0]            rsp_tuser,  // cmd_valid[0], framed[1]
   output logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [BYTE_W-1:0]     csr_wdata
);

   localparam int IW = $clog2(RX_DEPTH);

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_SKIP_RD   = 3'd1;
   localparam logic [2:0] ST_SKIP_CHK  = 3'd2;
   localparam logic [2:0] ST_SCAN      = 3'd3;
   localparam logic [2:0] ST_EMIT_RD   = 3'd4;
   localparam logic [2:0] ST_EMIT_WAIT = 3'd5;
   localparam logic [2:0] ST_FINAL     = 3'd6;

   function automatic logic [IW-1:0] inc_idx(input logic [IW-1:0] i);
      return (i == IW'(RX_DEPTH - 1)) ? '0 : i + 1'b1;
   endfunction

   logic [2:0]        state_ff, state_in;
   logic [IW-1:0]     rd_idx_ff, rd_idx_in;
   logic [IW-1:0]     wr_idx_ff, wr_idx_in;
   logic [IW-1:0]     pend_ff, pend_in;
   logic              held_ff, held_in;
   logic [BYTE_W-1:0] hold_ff, hold_in;
   logic [BYTE_W-1:0] sil_ff, sil_in;
   logic [BYTE_W-1:0] end_first_ff, end_second_ff, sil_ticks_ff, hold_secs_ff;

   logic [IW-1:0]     scan_ptr_ff, scan_ptr_in;
   logic [IW-1:0]     scan_cnt_ff, scan_cnt_in;
   logic [IW-1:0]     chk_j_ff, chk_j_in;
   logic              chk_valid_ff, chk_valid_in;
   logic [BYTE_W-1:0] prev_ff, prev_in;
   logic              framed_ff, framed_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [15:0]       rsp_data_ff, rsp_data_in;
   logic [1:0]        rsp_user_ff, rsp_user_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              ram_we, ram_re;
   logic [IW-1:0]     ram_raddr;
   logic [BYTE_W-1:0] ram_rdata;

   logic              out_free, req_fire, not_full;
   logic              res_load, res_cv, res_framed, res_last, res_drop;
   logic [BYTE_W-1:0] res_byte;
   logic              found;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign req_fire   = req_tvalid && req_tready;
   assign not_full   = pend_ff < IW'(RX_DEPTH - 2);
   assign ram_we     = req_fire && (req_tuser == KIND_BYTE) && not_full;

   ulfr_ram #(
      .WIDTH(BYTE_W),
      .DEPTH(RX_DEPTH)
   ) u_ring (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(wr_idx_ff),
      .wr_data(req_tdata),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      rd_idx_in    = rd_idx_ff;
      wr_idx_in    = wr_idx_ff;
      pend_in      = pend_ff;
      held_in      = held_ff;
      hold_in      = hold_ff;
      sil_in       = sil_ff;
      scan_ptr_in  = scan_ptr_ff;
      scan_cnt_in  = scan_cnt_ff;
      chk_j_in     = chk_j_ff;
      chk_valid_in = chk_valid_ff;
      prev_in      = prev_ff;
      framed_in    = framed_ff;
      ram_re       = 1'b0;
      ram_raddr    = scan_ptr_ff;
      res_load     = 1'b0;
      res_byte     = '0;
      res_cv       = 1'b0;
      res_framed   = 1'b0;
      res_last     = 1'b1;
      res_drop     = 1'b0;
      found        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               res_load = 1'b1;
               unique case (req_tuser)
                  KIND_BYTE: begin
                     if (not_full) begin
                        wr_idx_in = inc_idx(wr_idx_ff);
                        pend_in   = pend_ff + 1'b1;
                     end else begin
                        res_drop = 1'b1;
                     end
                     sil_in = sil_ticks_ff;
                  end
                  KIND_PROCESS: begin
                     if (!held_ff) begin
                        res_load = 1'b0;
                        state_in = ST_SKIP_RD;
                     end
                  end
                  KIND_DONE: begin
                     held_in = 1'b0;
                     hold_in = '0;
                  end
                  KIND_SILENCE: begin
                     if (sil_ff != '0) begin
                        sil_in = sil_ff - 1'b1;
                        if (sil_ff == 8'd1) begin
                           wr_idx_in = rd_idx_ff;
                           pend_in   = '0;
                        end
                     end
                  end
                  KIND_SECOND: begin
                     if (hold_ff != '0) begin
                        hold_in = hold_ff - 1'b1;
                        if (hold_ff == 8'd1) begin
                           held_in = 1'b0;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SKIP_RD: begin
            if (pend_ff == '0) begin
               scan_ptr_in  = rd_idx_ff;
               scan_cnt_in  = '0;
               chk_valid_in = 1'b0;
               state_in     = ST_SCAN;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = rd_idx_ff;
               state_in  = ST_SKIP_CHK;
            end
         end
         ST_SKIP_CHK: begin
            if (is_junk(ram_rdata)) begin
               rd_idx_in = inc_idx(rd_idx_ff);
               pend_in   = pend_ff - 1'b1;
               state_in  = ST_SKIP_RD;
            end else begin
               scan_ptr_in  = rd_idx_ff;
               scan_cnt_in  = '0;
               chk_valid_in = 1'b0;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (chk_valid_ff) begin
               found = (chk_j_ff != '0) && (prev_ff == end_first_ff)
                       && (ram_rdata == end_second_ff);
               prev_in = ram_rdata;
            end
            if (found) begin
               // The scan pointer already sits one past the terminator.
               rd_idx_in    = scan_ptr_ff;
               scan_ptr_in  = rd_idx_ff;
               pend_in      = pend_ff - chk_j_ff - 1'b1;
               scan_cnt_in  = chk_j_ff - 1'b1;
               held_in      = 1'b1;
               hold_in      = hold_secs_ff;
               chk_valid_in = 1'b0;
               framed_in    = 1'b1;
               state_in     = (chk_j_ff == IW'(1)) ? ST_FINAL : ST_EMIT_RD;
            end else if (!chk_valid_ff && (scan_cnt_ff == pend_ff)) begin
               framed_in = 1'b0;
               state_in  = ST_FINAL;
            end else if (scan_cnt_ff != pend_ff) begin
               ram_re       = 1'b1;
               ram_raddr    = scan_ptr_ff;
               scan_ptr_in  = inc_idx(scan_ptr_ff);
               scan_cnt_in  = scan_cnt_ff + 1'b1;
               chk_j_in     = scan_cnt_ff;
               chk_valid_in = 1'b1;
            end else begin
               chk_valid_in = 1'b0;
            end
         end
         ST_EMIT_RD: begin
            ram_re    = 1'b1;
            ram_raddr = scan_ptr_ff;
            state_in  = ST_EMIT_WAIT;
         end
         ST_EMIT_WAIT: begin
            if (out_free) begin
               res_load    = 1'b1;
               res_byte    = ram_rdata;
               res_cv      = 1'b1;
               res_framed  = 1'b1;
               res_last    = (scan_cnt_ff == IW'(1));
               scan_ptr_in = inc_idx(scan_ptr_ff);
               scan_cnt_in = scan_cnt_ff - 1'b1;
               state_in    = (scan_cnt_ff == IW'(1)) ? ST_IDLE : ST_EMIT_RD;
            end
         end
         ST_FINAL: begin
            if (out_free) begin
               res_load   = 1'b1;
               res_framed = framed_ff;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      if (res_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {res_drop, PEND_OUT_W'(pend_in), held_in, res_byte};
         rsp_user_in  = {res_framed, res_cv};
         rsp_last_in  = res_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_idx_ff     <= '0;
         wr_idx_ff     <= '0;
         pend_ff       <= '0;
         held_ff       <= 1'b0;
         hold_ff       <= '0;
         sil_ff        <= '0;
         chk_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         end_first_ff  <= RST_END_FIRST;
         end_second_ff <= RST_END_SECOND;
         sil_ticks_ff  <= RST_SILENCE_TICKS;
         hold_secs_ff  <= RST_HOLD_SECONDS;
      end else begin
         state_ff     <= state_in;
         rd_idx_ff    <= rd_idx_in;
         wr_idx_ff    <= wr_idx_in;
         pend_ff      <= pend_in;
         held_ff      <= held_in;
         hold_ff      <= hold_in;
         sil_ff       <= sil_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_END_FIRST:     end_first_ff  <= csr_wdata;
               CSR_END_SECOND:    end_second_ff <= csr_wdata;
               CSR_SILENCE_TICKS: sil_ticks_ff  <= csr_wdata;
               CSR_HOLD_SECONDS:  hold_secs_ff  <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ptr_ff <= scan_ptr_in;
      scan_cnt_ff <= scan_cnt_in;
      chk_j_ff    <= chk_j_in;
      prev_ff     <= prev_in;
      framed_ff   <= framed_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= IW'(RX_DEPTH - 2))
      else $error("pending count exceeds ring capacity");

   a_line_byte_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_user_ff[0]) |-> (rsp_user_ff[1] && rsp_data_ff[8]))
      else $error("line byte shown without framed and held");

   a_emit_after_frame: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && state_in == ST_EMIT_RD) |=> held_ff)
      else $error("line emission started without a held command");

   a_no_read_when_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !ram_re)
      else $error("ring read issued while idle");

endmodule

// File: hw/rtl/ulfr_ram.sv
// ----------------------------------------------------------------------------
// ulfr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ulfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
